// File: hdl/byte_playfair_digraph_cipher_defines.svh
// assertion macros for the byte playfair digraph cipher
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef BYTE_PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH
`define BYTE_PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH
`ifndef SYNTHESIS
// property must hold at every clock once out of reset
`define BPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be seen once out of reset
`define BPF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define BPF_ASSERT(lbl, prop, msg)
`define BPF_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: hdl/bpf_pkg.sv
// shared types, codes and constants of the byte playfair digraph cipher
// no dependencies
package bpf_pkg;

  localparam int unsigned GridSide   = 16;
  localparam int unsigned SideW      = $clog2(GridSide);
  localparam int unsigned SideMask   = GridSide - 1;
  localparam int unsigned CellW      = 2 * SideW;
  localparam int unsigned GridCells  = GridSide * GridSide;
  localparam int unsigned FillW      = CellW + 1;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // command codes as they arrive on the input stream
  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_KEY     = 3'd1;
  localparam logic [2:0] CMD_FINISH  = 3'd2;
  localparam logic [2:0] CMD_ENCRYPT = 3'd3;
  localparam logic [2:0] CMD_DECRYPT = 3'd4;

  typedef enum logic [2:0] {
    OP_START,
    OP_KEY,
    OP_FINISH,
    OP_ENCRYPT,
    OP_DECRYPT,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUP       = 2'd1,
    ST_NOT_READY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POS,
    S_GRID,
    S_FILL,
    S_MAP
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [CellW-1:0] first_byte;
    logic [CellW-1:0] second_byte;
  } item_t;

  // queue head as seen by the execution side
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic             grid_ready;
    logic [FillW-1:0] fill_index;
  } back_stat_t;

  function automatic op_e decode_cmd(input logic [2:0] cmd);
    op_e op;
    unique case (cmd)
      CMD_START:   op = OP_START;
      CMD_KEY:     op = OP_KEY;
      CMD_FINISH:  op = OP_FINISH;
      CMD_ENCRYPT: op = OP_ENCRYPT;
      CMD_DECRYPT: op = OP_DECRYPT;
      default:     op = OP_NOP;
    endcase
    return op;
  endfunction

  // one step right/down for encrypt, one step left/up (mod side) for decrypt
  function automatic logic [SideW-1:0] side_step(input logic dec);
    return dec ? SideW'(SideMask) : SideW'(1);
  endfunction

endpackage

// File: hdl/bpf_ram.sv
// generic memory: one write port, two read ports with registered data
// no dependencies
module bpf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: hdl/bpf_front.sv
// front end: takes input beats, decodes the command, holds them in a short queue
// depends on bpf_pkg
module bpf_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [2:0]                in_cmd_i,
  input  logic [bpf_pkg::CellW-1:0] in_first_i,
  input  logic [bpf_pkg::CellW-1:0] in_second_i,
  output bpf_pkg::queue_head_t      head_o,
  input  logic                      pop_i
);

  bpf_pkg::item_t             slot_q [bpf_pkg::QueueDepth];
  logic [bpf_pkg::QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [bpf_pkg::QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [bpf_pkg::QCntW-1:0]  count_q, count_d;
  logic                       push;
  logic                       pop;

  assign in_ready_o = (count_q != bpf_pkg::QCntW'(bpf_pkg::QueueDepth));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? bpf_pkg::QPtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop ? bpf_pkg::QPtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = bpf_pkg::QCntW'(count_q + 1'b1);
    end else if (pop && !push) begin
      count_d = bpf_pkg::QCntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q].op          <= bpf_pkg::decode_cmd(in_cmd_i);
      slot_q[wr_ptr_q].first_byte  <= in_first_i;
      slot_q[wr_ptr_q].second_byte <= in_second_i;
    end
  end

endmodule

// File: hdl/bpf_back.sv
// back end: sequencer over the grid and inverse memories, seen bitmap, result register
// depends on bpf_pkg and bpf_ram
module bpf_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bpf_pkg::queue_head_t      head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [bpf_pkg::CellW-1:0] out_first_o,
  output logic [bpf_pkg::CellW-1:0] out_second_o,
  output bpf_pkg::status_e          out_status_o,
  output bpf_pkg::back_stat_t       stat_o
);

  bpf_pkg::state_e                state_q, state_d;
  logic [bpf_pkg::FillW-1:0]      fill_q, fill_d;
  logic [bpf_pkg::FillW-1:0]      cnt_q, cnt_d;
  logic                           ready_q, ready_d;
  logic                           dec_q, dec_d;
  logic [bpf_pkg::GridCells-1:0]  seen_q, seen_d;
  logic                           out_vld_q, out_vld_d;
  logic [bpf_pkg::CellW-1:0]      out_first_q, out_first_d;
  logic [bpf_pkg::CellW-1:0]      out_second_q, out_second_d;
  bpf_pkg::status_e               out_status_q, out_status_d;

  logic                           out_free;
  logic                           fill_room;
  logic [bpf_pkg::CellW-1:0]      sweep_idx;

  logic                           grid_we;
  logic [bpf_pkg::CellW-1:0]      grid_wdata;
  logic [bpf_pkg::CellW-1:0]      grid_raddr_a;
  logic [bpf_pkg::CellW-1:0]      grid_rd_a, grid_rd_b;
  logic                           pos_we;
  logic [bpf_pkg::CellW-1:0]      pos_rd_a, pos_rd_b;

  logic [bpf_pkg::SideW-1:0]      ra, ca, rb, cb, step;
  logic [bpf_pkg::CellW-1:0]      na, nb;

  assign out_free  = !out_vld_q || out_ready_i;
  assign fill_room = !fill_q[bpf_pkg::FillW-1];
  assign sweep_idx = cnt_q[bpf_pkg::CellW-1:0];

  // new cells from the two looked-up positions
  always_comb begin
    ra   = pos_rd_a[bpf_pkg::CellW-1:bpf_pkg::SideW];
    ca   = pos_rd_a[bpf_pkg::SideW-1:0];
    rb   = pos_rd_b[bpf_pkg::CellW-1:bpf_pkg::SideW];
    cb   = pos_rd_b[bpf_pkg::SideW-1:0];
    step = bpf_pkg::side_step(dec_q);
    if (ra == rb) begin
      na = {ra, bpf_pkg::SideW'(ca + step)};
      nb = {rb, bpf_pkg::SideW'(cb + step)};
    end else if (ca == cb) begin
      na = {bpf_pkg::SideW'(ra + step), ca};
      nb = {bpf_pkg::SideW'(rb + step), cb};
    end else begin
      na = {ra, cb};
      nb = {rb, ca};
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpf_pkg::S_IDLE: begin
        if (head_i.valid && out_free) begin
          case (head_i.item.op) inside
            bpf_pkg::OP_FINISH: state_d = bpf_pkg::S_FILL;
            bpf_pkg::OP_ENCRYPT, bpf_pkg::OP_DECRYPT: begin
              if (ready_q) begin
                state_d = bpf_pkg::S_POS;
              end
            end
            default: state_d = bpf_pkg::S_IDLE;
          endcase
        end
      end
      bpf_pkg::S_POS:  state_d = bpf_pkg::S_GRID;
      bpf_pkg::S_GRID: state_d = bpf_pkg::S_IDLE;
      bpf_pkg::S_FILL: begin
        if (sweep_idx == bpf_pkg::CellW'(bpf_pkg::GridCells - 1)) begin
          state_d = bpf_pkg::S_MAP;
        end
      end
      bpf_pkg::S_MAP: begin
        if (cnt_q[bpf_pkg::FillW-1]) begin
          state_d = bpf_pkg::S_IDLE;
        end
      end
      default: state_d = bpf_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    pop_o        = 1'b0;
    grid_we      = 1'b0;
    grid_wdata   = head_i.item.first_byte;
    grid_raddr_a = na;
    pos_we       = 1'b0;
    fill_d       = fill_q;
    cnt_d        = cnt_q;
    ready_d      = ready_q;
    dec_d        = dec_q;
    seen_d       = seen_q;
    out_vld_d    = out_vld_q && !out_ready_i;
    out_first_d  = out_first_q;
    out_second_d = out_second_q;
    out_status_d = out_status_q;
    unique case (state_q)
      bpf_pkg::S_IDLE: begin
        if (head_i.valid && out_free) begin
          pop_o        = 1'b1;
          out_first_d  = '0;
          out_second_d = '0;
          out_status_d = bpf_pkg::ST_DONE;
          case (head_i.item.op) inside
            bpf_pkg::OP_START: begin
              seen_d    = '0;
              fill_d    = '0;
              ready_d   = 1'b0;
              out_vld_d = 1'b1;
            end
            bpf_pkg::OP_KEY: begin
              out_vld_d = 1'b1;
              if (seen_q[head_i.item.first_byte]) begin
                out_status_d = bpf_pkg::ST_DUP;
              end else if (fill_room) begin
                seen_d[head_i.item.first_byte] = 1'b1;
                grid_we = 1'b1;
                fill_d  = bpf_pkg::FillW'(fill_q + 1'b1);
              end
            end
            bpf_pkg::OP_FINISH: begin
              cnt_d = '0;
            end
            bpf_pkg::OP_ENCRYPT, bpf_pkg::OP_DECRYPT: begin
              if (ready_q) begin
                dec_d = (head_i.item.op == bpf_pkg::OP_DECRYPT);
              end else begin
                out_status_d = bpf_pkg::ST_NOT_READY;
                out_vld_d    = 1'b1;
              end
            end
            default: begin
              out_vld_d = 1'b1;
            end
          endcase
        end
      end
      bpf_pkg::S_POS: begin
        grid_raddr_a = na;
      end
      bpf_pkg::S_GRID: begin
        out_vld_d    = 1'b1;
        out_first_d  = grid_rd_a;
        out_second_d = grid_rd_b;
        out_status_d = bpf_pkg::ST_DONE;
      end
      bpf_pkg::S_FILL: begin
        grid_wdata = sweep_idx;
        if (!seen_q[sweep_idx] && fill_room) begin
          grid_we           = 1'b1;
          seen_d[sweep_idx] = 1'b1;
          fill_d            = bpf_pkg::FillW'(fill_q + 1'b1);
        end
        if (sweep_idx == bpf_pkg::CellW'(bpf_pkg::GridCells - 1)) begin
          cnt_d = '0;
        end else begin
          cnt_d = bpf_pkg::FillW'(cnt_q + 1'b1);
        end
      end
      bpf_pkg::S_MAP: begin
        // read cell cnt, write its inverse in the next cycle
        grid_raddr_a = sweep_idx;
        pos_we       = (cnt_q != '0);
        cnt_d        = bpf_pkg::FillW'(cnt_q + 1'b1);
        if (cnt_q[bpf_pkg::FillW-1]) begin
          ready_d      = 1'b1;
          out_vld_d    = 1'b1;
          out_first_d  = '0;
          out_second_d = '0;
          out_status_d = bpf_pkg::ST_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bpf_pkg::S_IDLE;
      fill_q    <= '0;
      cnt_q     <= '0;
      ready_q   <= 1'b0;
      dec_q     <= 1'b0;
      seen_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      cnt_q     <= cnt_d;
      ready_q   <= ready_d;
      dec_q     <= dec_d;
      seen_q    <= seen_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_first_q  <= out_first_d;
    out_second_q <= out_second_d;
    out_status_q <= out_status_d;
  end

  bpf_ram #(
    .Width (bpf_pkg::CellW),
    .Depth (bpf_pkg::GridCells)
  ) u_grid_ram (
    .clk_i     (clk_i),
    .we_i      (grid_we),
    .waddr_i   (fill_q[bpf_pkg::CellW-1:0]),
    .wdata_i   (grid_wdata),
    .raddr_a_i (grid_raddr_a),
    .raddr_b_i (nb),
    .rdata_a_o (grid_rd_a),
    .rdata_b_o (grid_rd_b)
  );

  bpf_ram #(
    .Width (bpf_pkg::CellW),
    .Depth (bpf_pkg::GridCells)
  ) u_pos_ram (
    .clk_i     (clk_i),
    .we_i      (pos_we),
    .waddr_i   (grid_rd_a),
    .wdata_i   (bpf_pkg::CellW'(cnt_q - 1'b1)),
    .raddr_a_i (head_i.item.first_byte),
    .raddr_b_i (head_i.item.second_byte),
    .rdata_a_o (pos_rd_a),
    .rdata_b_o (pos_rd_b)
  );

  assign out_valid_o       = out_vld_q;
  assign out_first_o       = out_first_q;
  assign out_second_o      = out_second_q;
  assign out_status_o      = out_status_q;
  assign stat_o.grid_ready = ready_q;
  assign stat_o.fill_index = fill_q;

endmodule

// File: hdl/byte_playfair_digraph_cipher.sv
// top level of the byte playfair digraph cipher (16x16 grid of all byte values)
// depends on bpf_pkg, bpf_front, bpf_back and the assertion macro header
//
// usage:
//   the slave stream carries one command per beat: tuser holds the command code
//   (start key, key byte, finish grid, encrypt pair, decrypt pair), tdata the two bytes.
//   the master stream returns exactly one beat per command: tdata holds the two
//   transformed bytes (zero for non-cipher commands), tuser the status code
//   (done, duplicate key byte, grid not ready).
// execution:
//   an accepted beat is written into the queue and executed from the queue head.
//   start, key byte, unused codes and not-ready ciphers finish in the idle state,
//   so they stream at one beat per cycle while the receiver takes the results.
//   an encrypt or decrypt pair steps through an inverse table read, a grid read,
//   then the result register; the sequencer pops no new beat until it is done.
//   finish holds the sequencer for a fill pass over the seen bitmap, then a pass
//   streaming the grid through the inverse table.
// reset clears the queue, seen bitmap, fill index and ready flag; the grid and
// inverse memories keep their contents until written.
// a stalled receiver holds the result register; the two-entry queue keeps taking
// beats until full, then tready drops.
`include "byte_playfair_digraph_cipher_defines.svh"

module byte_playfair_digraph_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] first_byte, [15:8] second_byte
  input  logic [2:0]  s_axis_tuser,  // [2:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] first_out, [15:8] second_out
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  // queue head from the front end, popped by the sequencer
  bpf_pkg::queue_head_t      head;
  logic                      pop;
  // sequencer bookkeeping, watched by the checks below
  bpf_pkg::back_stat_t       bk_stat;
  logic [bpf_pkg::CellW-1:0] res_first;
  logic [bpf_pkg::CellW-1:0] res_second;
  bpf_pkg::status_e          res_status;

  bpf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_first_i  (s_axis_tdata[7:0]),
    .in_second_i (s_axis_tdata[15:8]),
    .head_o      (head),
    .pop_i       (pop)
  );

  bpf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_first_o  (res_first),
    .out_second_o (res_second),
    .out_status_o (res_status),
    .stat_o       (bk_stat)
  );

  // pack the result beat, first byte in the low half
  assign m_axis_tdata = {res_second, res_first};
  assign m_axis_tuser = res_status;

  // a ready grid has every cell filled
  `BPF_ASSERT(a_ready_full, bk_stat.grid_ready |-> bk_stat.fill_index[bpf_pkg::FillW-1], "grid ready before fill complete")
  // the fill index never runs past the last cell
  `BPF_ASSERT_NEVER(a_fill_bound, bk_stat.fill_index[bpf_pkg::FillW-1] && (bk_stat.fill_index[bpf_pkg::FillW-2:0] != '0), "fill index past grid end")
  // a not-ready answer carries no cipher bytes
  `BPF_ASSERT(a_not_ready_zero, (m_axis_tvalid && (m_axis_tuser == bpf_pkg::ST_NOT_READY)) |-> (m_axis_tdata == '0), "not-ready result with data")

endmodule

// File: tb/sv/tb_byte_playfair_digraph_cipher.sv
`timescale 1ns / 100ps
// self-checking testbench for byte_playfair_digraph_cipher: stream stimulus with random
// gaps and stalls, a scoreboard class that predicts every result beat and compares it
// depends on bpf_pkg and the byte_playfair_digraph_cipher rtl
module tb_byte_playfair_digraph_cipher;
  import bpf_pkg::*;

  // codes 5..7 are not decoded by the block and must come back as a plain done
  localparam logic [2:0] CMD_SPARE_FIRST = CMD_DECRYPT + 3'd1;
  localparam int         QuietLimit      = 4000;  // finish alone holds the sequencer for a full fill and map pass
  localparam int         DrainCycles     = 40;
  localparam int         RandomBeats     = 1950;
  localparam int         MaxReports      = 20;

  typedef struct packed {
    logic [7:0] first_out;
    logic [7:0] second_out;
    status_e    status;
  } pair_result_t;

  // predicts each result beat from the accepted command beats and checks the
  // result beats in order against it
  class cipher_scoreboard;
    logic [7:0]       grid_tab [GridCells];  // byte at each row-major cell
    logic [7:0]       cell_of  [GridCells];  // cell of each byte
    bit               seen     [GridCells];
    logic [FillW-1:0] fill_count;
    bit               ready;
    pair_result_t     expected_q[$];
    int errors, n_checked;
    int n_keys, n_dups, n_finish, n_not_ready, n_spare;
    int n_row, n_col, n_rect, n_enc, n_dec;

    function new();
      foreach (grid_tab[i]) begin
        grid_tab[i] = '0;
        cell_of[i]  = '0;
        seen[i]     = 1'b0;
      end
      fill_count = '0;
      ready      = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_beat(input logic [2:0] cmd, input logic [7:0] a, input logic [7:0] b);
      pair_result_t     res;
      logic [7:0]       pa, pb, na, nb;
      logic [SideW-1:0] ra, ca, rb, cb, stp;
      res = '{first_out: 8'h00, second_out: 8'h00, status: ST_DONE};
      case (cmd)
        CMD_START: begin
          foreach (seen[i]) seen[i] = 1'b0;
          fill_count = '0;
          ready      = 1'b0;
        end
        CMD_KEY: begin
          n_keys++;
          if (seen[a]) begin
            res.status = ST_DUP;
            n_dups++;
          end else if (fill_count < GridCells) begin
            seen[a] = 1'b1;
            grid_tab[fill_count[7:0]] = a;
            fill_count++;
          end
        end
        CMD_FINISH: begin
          n_finish++;
          // unseen bytes fill the tail in ascending order, then rebuild the inverse
          for (int v = 0; v < GridCells; v++) begin
            if (!seen[v] && fill_count < GridCells) begin
              grid_tab[fill_count[7:0]] = 8'(v);
              fill_count++;
              seen[v] = 1'b1;
            end
          end
          for (int c = 0; c < GridCells; c++) cell_of[grid_tab[c]] = 8'(c);
          ready = 1'b1;
        end
        CMD_ENCRYPT, CMD_DECRYPT: begin
          if (!ready) begin
            res.status = ST_NOT_READY;
            n_not_ready++;
          end else begin
            if (cmd == CMD_DECRYPT) n_dec++;
            else n_enc++;
            pa  = cell_of[a];
            pb  = cell_of[b];
            ra  = pa[7:4];
            ca  = pa[3:0];
            rb  = pb[7:4];
            cb  = pb[3:0];
            // decrypt steps by side-1, i.e. one back with wrap
            stp = (cmd == CMD_DECRYPT) ? SideW'(SideMask) : SideW'(1);
            if (ra == rb) begin
              na = {ra, 4'(ca + stp)};
              nb = {rb, 4'(cb + stp)};
              n_row++;
            end else if (ca == cb) begin
              na = {4'(ra + stp), ca};
              nb = {4'(rb + stp), cb};
              n_col++;
            end else begin
              na = {ra, cb};
              nb = {rb, ca};
              n_rect++;
            end
            res.first_out  = grid_tab[na];
            res.second_out = grid_tab[nb];
          end
        end
        default: n_spare++;
      endcase
      expected_q = {expected_q, res};
    endfunction

    function void check_beat(input logic [15:0] data, input logic [1:0] user);
      pair_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: result beat with nothing expected, actual data %h status %h",
                   $time, data, user);
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      if (data[7:0] !== want.first_out) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: first_out expected %h actual %h", $time, want.first_out, data[7:0]);
      end
      if (data[15:8] !== want.second_out) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: second_out expected %h actual %h", $time, want.second_out,
                   data[15:8]);
      end
      if (user !== want.status) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: status expected %0d actual %0d", $time, want.status, user);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [7:0] first_byte, [15:8] second_byte
  logic [2:0]  s_axis_tuser;   // [2:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] first_out, [15:8] second_out
  logic [1:0]  m_axis_tuser;   // [1:0] status

  cipher_scoreboard sb = new();
  bit tx_steady;               // no idle gaps on the command side while set
  int beats_sent;
  int quiet_cycles;
  int sessions;

  byte_playfair_digraph_cipher DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // one command beat: optional idle gap, then hold valid until the handshake;
  // valid stays high on return so back-to-back beats never toggle it
  task automatic send_beat(input logic [2:0] cmd, input logic [7:0] a, input logic [7:0] b);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_beat(cmd, a, b);
    beats_sent++;
  endtask

  // an undecoded command code with random bytes
  task automatic send_spare();
    send_beat(CMD_SPARE_FIRST + 3'($urandom_range(0, 2)), 8'($urandom), 8'($urandom));
  endtask

  // pair shaped from the current grid so that rows, columns, rectangles and
  // identical bytes all come up often
  task automatic send_cipher(input logic [2:0] cmd);
    logic [3:0] r1, r2, c1, c2;
    logic [7:0] a, b;
    r1 = 4'($urandom);
    r2 = 4'($urandom);
    c1 = 4'($urandom);
    c2 = 4'($urandom);
    case ($urandom_range(0, 5))
      0, 1: begin
        a = 8'($urandom);
        b = 8'($urandom);
      end
      2: begin
        a = sb.grid_tab[{r1, c1}];
        b = sb.grid_tab[{r1, c2}];
      end
      3: begin
        a = sb.grid_tab[{r1, c1}];
        b = sb.grid_tab[{r2, c1}];
      end
      4: begin
        a = 8'($urandom);
        b = a;
      end
      default: begin
        a = sb.grid_tab[{r1, c1}];
        b = sb.grid_tab[{r2, c2}];
      end
    endcase
    send_beat(cmd, a, b);
  endtask

  // start, key bytes, finish, then a run of pairs; sprinkled with ignored
  // codes, early ciphers, late key bytes and repeated finishes
  task automatic run_session(input int session_no);
    logic [7:0] key_log[$];
    logic [7:0] pool[GridCells];
    logic [7:0] k, tmp;
    int         kind, n_keys, n_pairs, j;
    tx_steady = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 7) == 0) send_spare();
    send_beat(CMD_START, 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 5) == 0)
      send_cipher($urandom_range(0, 1) ? CMD_ENCRYPT : CMD_DECRYPT);
    kind = (session_no == 0) ? 11 : $urandom_range(0, 13);
    if (kind >= 13 || session_no == 0) begin
      // full key: every byte once, in shuffled order, then a few repeats
      for (int i = 0; i < GridCells; i++) pool[i] = 8'(i);
      for (int i = GridCells - 1; i > 0; i--) begin
        j       = $urandom_range(0, i);
        tmp     = pool[i];
        pool[i] = pool[j];
        pool[j] = tmp;
      end
      foreach (pool[i]) send_beat(CMD_KEY, pool[i], 8'($urandom));
      repeat ($urandom_range(1, 3)) send_beat(CMD_KEY, 8'($urandom), 8'($urandom));
    end else begin
      n_keys = (kind < 9) ? $urandom_range(0, 16) : $urandom_range(17, 80);
      repeat (n_keys) begin
        if (key_log.size() > 0 && $urandom_range(0, 4) == 0)
          k = key_log[$urandom_range(0, key_log.size() - 1)];
        else
          k = 8'($urandom);
        key_log = {key_log, k};
        send_beat(CMD_KEY, k, 8'($urandom));
      end
    end
    send_beat(CMD_FINISH, 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 9) == 0) send_beat(CMD_FINISH, 8'($urandom), 8'($urandom));
    if ($urandom_range(0, 9) == 0) send_beat(CMD_KEY, 8'($urandom), 8'($urandom));
    tx_steady = ($urandom_range(0, 3) == 0);
    n_pairs   = $urandom_range(16, 64);
    repeat (n_pairs) begin
      if ($urandom_range(0, 31) == 0) send_spare();
      else send_cipher($urandom_range(0, 1) ? CMD_ENCRYPT : CMD_DECRYPT);
    end
  endtask

  // result side: random stalls per beat, with stretches of none, checks each beat
  initial begin : result_sink
    int stall, stretch_left;
    bit steady;
    m_axis_tready = 1'b0;
    stretch_left  = 0;
    steady        = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (stretch_left == 0) begin
        steady       = ($urandom_range(0, 2) == 0);
        stretch_left = $urandom_range(8, 48);
      end
      stretch_left--;
      stall = steady ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      sb.check_beat(m_axis_tdata, m_axis_tuser);
    end
  end

  // watchdog: any stretch without a beat on either side longer than the limit
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding", $time, QuietLimit,
               sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int target;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_START;
    tx_steady     = 1'b0;
    beats_sent    = 0;
    quiet_cycles  = 0;
    sessions      = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: ciphers before any finish, ignored codes, a short key holding both byte
    // extremes with a repeat of FF, double finish, key byte after finish
    send_beat(CMD_ENCRYPT, 8'hFF, 8'h00);
    send_beat(CMD_DECRYPT, 8'h00, 8'hFF);
    send_beat(CMD_SPARE_FIRST, 8'hFF, 8'hFF);
    send_beat(CMD_SPARE_FIRST + 3'd1, 8'h00, 8'h00);
    send_beat(CMD_SPARE_FIRST + 3'd2, 8'hAA, 8'h55);
    send_beat(CMD_START, 8'h00, 8'h00);
    send_beat(CMD_KEY, 8'hFF, 8'hFF);
    send_beat(CMD_KEY, 8'h00, 8'h00);
    send_beat(CMD_KEY, 8'hA5, 8'h5A);
    send_beat(CMD_KEY, 8'hFF, 8'h00);
    send_beat(CMD_FINISH, 8'h00, 8'h00);
    send_beat(CMD_FINISH, 8'hFF, 8'hFF);
    send_beat(CMD_KEY, 8'h33, 8'hCC);
    // row wrap right and left, column wrap down and up, rectangles, identical bytes
    send_beat(CMD_ENCRYPT, sb.grid_tab[8'h0F], sb.grid_tab[8'h03]);
    send_beat(CMD_DECRYPT, sb.grid_tab[8'h00], sb.grid_tab[8'h05]);
    send_beat(CMD_ENCRYPT, sb.grid_tab[8'hF2], sb.grid_tab[8'h42]);
    send_beat(CMD_DECRYPT, sb.grid_tab[8'h07], sb.grid_tab[8'h97]);
    send_beat(CMD_ENCRYPT, sb.grid_tab[8'h00], sb.grid_tab[8'hFF]);
    send_beat(CMD_DECRYPT, sb.grid_tab[8'h11], sb.grid_tab[8'hC8]);
    send_beat(CMD_ENCRYPT, 8'hFF, 8'hFF);
    send_beat(CMD_DECRYPT, 8'h00, 8'h00);
    // restart drops readiness; an empty key gives the ascending grid
    send_beat(CMD_START, 8'h5A, 8'hA5);
    send_beat(CMD_ENCRYPT, 8'h12, 8'h34);
    send_beat(CMD_FINISH, 8'h00, 8'h00);
    send_beat(CMD_ENCRYPT, 8'h00, 8'hFF);

    target = beats_sent + RandomBeats;
    while (beats_sent < target) begin
      run_session(sessions);
      sessions++;
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d command beats over %0d key sessions: %0d key bytes (%0d repeats),",
             beats_sent, sessions, sb.n_keys, sb.n_dups);
    $display("  %0d finishes, pairs: %0d encrypt, %0d decrypt (%0d row, %0d column,",
             sb.n_finish, sb.n_enc, sb.n_dec, sb.n_row, sb.n_col);
    $display("  %0d rectangle), %0d not ready, %0d spare codes",
             sb.n_rect, sb.n_not_ready, sb.n_spare);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches in %0d checked results", sb.errors, sb.n_checked);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: byte_playfair_digraph_cipher.f
+incdir+hdl
hdl/bpf_pkg.sv
hdl/bpf_ram.sv
hdl/bpf_front.sv
hdl/bpf_back.sv
hdl/byte_playfair_digraph_cipher.sv
tb/sv/tb_byte_playfair_digraph_cipher.sv
